FILE: rtl/nearest_triangle_projection_core_assert.svh
// Assertion macros shared by the nearest triangle projection RTL.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef NEAREST_TRIANGLE_PROJECTION_CORE_ASSERT_SVH
`define NEAREST_TRIANGLE_PROJECTION_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NPTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NPTP_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define NPTP_ASSERT(lbl, prop, msg)
`define NPTP_ASSERT_IMP(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/nptp_pkg.sv
// Package for the nearest triangle projection core: widths, codes and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package nptp_pkg;
  localparam int COORD_W   = 32;
  localparam int MAX_TRI   = 4096;
  localparam int CNT_W     = 13;
  localparam int IDX_W     = 12;
  localparam int OPND_W    = 34;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int ACC_W     = 128;
  localparam int FRAC_W    = 33;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int DIST_W    = 63;
  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 176;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [2:0] REG_A  = 3'd0;
  localparam logic [2:0] REG_B  = 3'd1;
  localparam logic [2:0] REG_AB = 3'd2;
  localparam logic [2:0] REG_C  = 3'd3;
  localparam logic [2:0] REG_AC = 3'd4;
  localparam logic [2:0] REG_BC = 3'd5;
  localparam logic [2:0] REG_IN = 3'd6;

  typedef logic signed [OPND_W-1:0] opnd_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } mac_sh_e;

  typedef struct packed {
    logic    valid;
    logic    clear;
    logic    neg;
    mac_sh_e sh;
  } mac_ctl_t;
endpackage

FILE: rtl/nearest_triangle_projection_core.sv
// Top level of the nearest triangle projection core: sequencer and state.
// Uses nptp_pkg, nptp_mac, nptp_div and the assertion macro header.
//
// The input stream carries one transaction per item. tuser is the op bit:
// 0 loads the query point from the vertex A fields and restarts the search,
// 1 carries a triangle. tlast marks the final triangle of a mesh. The output
// stream carries one transaction per mesh, after its final triangle.
// A query transaction is taken while the block stays idle. A triangle runs
// through one shared multiply-accumulate unit (dot products, 64x64 products
// in four partial products) and one bit-serial divider. A vertex region
// needs no division, an edge one and the interior two; the divider finishes
// early when a weight comes out as zero or one. A triangle past the count
// limit is skipped without a search, and the final triangle of a mesh also
// passes through the result state.
// tready is high only while the block waits for a transaction.
// The result sits in an output register; if the receiver stalls, the block
// still takes the next mesh's triangles and only waits at the end of that
// mesh until the register is free. Reset clears the query point to the
// origin, empties the search and drops tvalid on the output.
`timescale 1ns / 1ps
`include "nearest_triangle_projection_core_assert.svh"
module nearest_triangle_projection_core
  import nptp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // ax, ay, az, bx, by, bz, vcx, vcy, vcz
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // found, triangle_index, near_x, near_y, near_z, region, dist_sq, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_SHIFT, ST_DOT, ST_VPROD, ST_SEL, ST_DIVGO, ST_DIVW,
    ST_TERM, ST_SAT, ST_DIST, ST_CMP, ST_NEXT, ST_OUT
  } state_e;

  state_e state_q;
  logic [2:0] grp_q;
  logic [3:0] cnt_q;

  logic signed [COORD_W-1:0] qp_q [3];
  logic signed [COORD_W-1:0] a_q [3], b_q [3], c_q [3], pt_q [3];
  logic signed [COORD_W:0]   ab_q [3], ac_q [3], ap_q [3], bc_q [3];
  logic signed [30:0]        sb_q [3], sc_q [3], sp_q [3], bp_q [3], cp_q [3];
  logic signed [63:0]        d_q [6];
  logic signed [ACC_W-1:0]   v_q [3];
  logic signed [35:0]        pt_acc_q [3];
  logic [FRAC_W-1:0]         w_q [2];
  logic [ACC_W-1:0]          num_q, den_q;
  logic [2:0]                region_q;
  logic                      interior_q, div_idx_q, last_q, searched_q;
  logic [DIST_W-1:0]         dist_q;

  logic [CNT_W-1:0]          tri_cnt_q;
  logic [63:0]               best_dist_q;
  logic [IDX_W-1:0]          best_idx_q;
  logic signed [COORD_W-1:0] best_pt_q [3];
  logic [2:0]                best_reg_q;
  logic                      have_best_q;
  logic                      m_valid_q;
  logic [OUT_DATA_W-1:0]     m_data_q;

  logic                      acc_in;
  logic signed [COORD_W-1:0] in_a [3], in_b [3], in_c [3];

  mac_ctl_t                  mac_ctl;
  opnd_t                     mac_a, mac_b;
  logic signed [ACC_W-1:0]   acc;
  logic                      div_start, div_done;
  logic [FRAC_W-1:0]         div_q;

  logic [1:0]                shamt;
  logic                      fit0, fit1, fit2;
  logic signed [30:0]        du, dv;
  logic signed [63:0]        vx, vy;
  logic [1:0]                part;
  logic                      pair;
  logic [1:0]                tk;
  logic signed [COORD_W:0]   tedge;
  logic [COORD_W:0]          tmag;
  logic [FRAC_W-1:0]         tw;
  logic [64:0]               trnd;
  logic [FRAC_W-1:0]         tval;
  logic signed [COORD_W:0]   ddiff;
  logic [2:0]                n_terms;

  logic [2:0]                sel_region;
  logic                      sel_skip;
  logic [ACC_W-1:0]          sel_num, sel_den;
  logic signed [65:0]        e43, e56;
  logic signed [ACC_W-1:0]   vsum;
  logic                      lez_va, lez_vb, lez_vc;
  logic [DIST_W-1:0]         dist_new;

  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_axis_tdata[i*COORD_W +: COORD_W];
      in_b[i] = s_axis_tdata[(i+3)*COORD_W +: COORD_W];
      in_c[i] = s_axis_tdata[(i+6)*COORD_W +: COORD_W];
    end
  end

  nptp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  assign div_start = (state_q == ST_DIVGO);

  nptp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    fit0 = 1'b1;
    fit1 = 1'b1;
    fit2 = 1'b1;
    for (int i = 0; i < 3; i++) begin
      fit0 &= (ab_q[i][32:29] == 4'h0 || ab_q[i][32:29] == 4'hF) &&
              (ac_q[i][32:29] == 4'h0 || ac_q[i][32:29] == 4'hF) &&
              (ap_q[i][32:29] == 4'h0 || ap_q[i][32:29] == 4'hF);
      fit1 &= (ab_q[i][32:30] == 3'h0 || ab_q[i][32:30] == 3'h7) &&
              (ac_q[i][32:30] == 3'h0 || ac_q[i][32:30] == 3'h7) &&
              (ap_q[i][32:30] == 3'h0 || ap_q[i][32:30] == 3'h7);
      fit2 &= (ab_q[i][32:31] == 2'h0 || ab_q[i][32:31] == 2'h3) &&
              (ac_q[i][32:31] == 2'h0 || ac_q[i][32:31] == 2'h3) &&
              (ap_q[i][32:31] == 2'h0 || ap_q[i][32:31] == 2'h3);
    end
    priority if (fit0) shamt = 2'd0;
    else if (fit1) shamt = 2'd1;
    else if (fit2) shamt = 2'd2;
    else shamt = 2'd3;
  end

  always_comb begin
    du = grp_q[0] ? sc_q[cnt_q[1:0]] : sb_q[cnt_q[1:0]];
    unique case (grp_q[2:1])
      2'd0:    dv = sp_q[cnt_q[1:0]];
      2'd1:    dv = bp_q[cnt_q[1:0]];
      default: dv = cp_q[cnt_q[1:0]];
    endcase
    pair = cnt_q[2];
    part = cnt_q[1:0];
    unique case (grp_q[1:0])
      2'd0: begin
        vx = pair ? d_q[2] : d_q[0];
        vy = pair ? d_q[1] : d_q[3];
      end
      2'd1: begin
        vx = pair ? d_q[0] : d_q[4];
        vy = pair ? d_q[5] : d_q[1];
      end
      default: begin
        vx = pair ? d_q[4] : d_q[2];
        vy = pair ? d_q[3] : d_q[5];
      end
    endcase
    tk = (grp_q >= 3'd3) ? 2'(grp_q - 3'd3) : grp_q[1:0];
    if (grp_q >= 3'd3) begin
      tedge = ac_q[tk];
      tw    = w_q[1];
    end else begin
      tw = w_q[0];
      unique case (region_q)
        REG_AC:  tedge = ac_q[tk];
        REG_BC:  tedge = bc_q[tk];
        default: tedge = ab_q[tk];
      endcase
    end
    tmag  = tedge[COORD_W] ? (COORD_W+1)'(-tedge) : tedge;
    trnd  = acc[64:0] + 65'h0_8000_0000;
    tval  = trnd[64:32];
    ddiff = (COORD_W+1)'(qp_q[cnt_q[1:0]]) - (COORD_W+1)'(pt_q[cnt_q[1:0]]);
  end

  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_q)
      ST_DOT: begin
        if (cnt_q < 4'd3) begin
          mac_ctl.valid = 1'b1;
          mac_ctl.clear = (cnt_q == 4'd0);
          mac_a = OPND_W'(du);
          mac_b = OPND_W'(dv);
        end
      end
      ST_VPROD: begin
        if (cnt_q < 4'd8) begin
          mac_ctl.valid = 1'b1;
          mac_ctl.clear = (cnt_q == 4'd0);
          mac_ctl.neg   = pair;
          mac_a = part[1] ? OPND_W'($signed(vx[63:32])) : $signed({2'b00, vx[31:0]});
          mac_b = part[0] ? OPND_W'($signed(vy[63:32])) : $signed({2'b00, vy[31:0]});
          unique case (part)
            2'd0:    mac_ctl.sh = SH_0;
            2'd3:    mac_ctl.sh = SH_64;
            default: mac_ctl.sh = SH_32;
          endcase
        end
      end
      ST_TERM: begin
        if (cnt_q == 4'd0) begin
          mac_ctl.valid = 1'b1;
          mac_ctl.clear = 1'b1;
          mac_a = $signed({1'b0, tmag});
          mac_b = $signed({1'b0, tw});
        end
      end
      ST_DIST: begin
        if (cnt_q < 4'd3) begin
          mac_ctl.valid = 1'b1;
          mac_ctl.clear = (cnt_q == 4'd0);
          mac_a = OPND_W'(ddiff);
          mac_b = OPND_W'(ddiff);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    lez_vc = v_q[0][ACC_W-1] || v_q[0] == '0;
    lez_vb = v_q[1][ACC_W-1] || v_q[1] == '0;
    lez_va = v_q[2][ACC_W-1] || v_q[2] == '0;
    e43  = 66'(d_q[3]) - 66'(d_q[2]);
    e56  = 66'(d_q[4]) - 66'(d_q[5]);
    vsum = v_q[0] + v_q[1] + v_q[2];
    sel_skip = 1'b0;
    sel_num  = '0;
    sel_den  = '0;
    priority if (d_q[0] <= 0 && d_q[1] <= 0) begin
      sel_region = REG_A;
    end else if (d_q[2] >= 0 && d_q[3] <= d_q[2]) begin
      sel_region = REG_B;
    end else if (lez_vc && d_q[0] >= 0 && d_q[2] <= 0) begin
      sel_region = REG_AB;
      sel_num    = ACC_W'(d_q[0]);
      sel_den    = ACC_W'(d_q[0]) - ACC_W'(d_q[2]);
      sel_skip   = (sel_den == '0);
    end else if (d_q[5] >= 0 && d_q[4] <= d_q[5]) begin
      sel_region = REG_C;
    end else if (lez_vb && d_q[1] >= 0 && d_q[5] <= 0) begin
      sel_region = REG_AC;
      sel_num    = ACC_W'(d_q[1]);
      sel_den    = ACC_W'(d_q[1]) - ACC_W'(d_q[5]);
      sel_skip   = (sel_den == '0);
    end else if (lez_va && e43 >= 0 && e56 >= 0) begin
      sel_region = REG_BC;
      sel_num    = ACC_W'(e43);
      sel_den    = ACC_W'(e43) + ACC_W'(e56);
      sel_skip   = (sel_den == '0);
    end else begin
      sel_region = REG_IN;
      sel_num    = v_q[1];
      sel_den    = vsum;
      sel_skip   = vsum[ACC_W-1] || vsum == '0;
    end
  end

  assign n_terms  = interior_q ? 3'd6 : 3'd3;
  assign dist_new = (acc[ACC_W-1:DIST_W] != '0) ? DIST_MAX : acc[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    if (acc_in && s_axis_tuser) begin
      for (int i = 0; i < 3; i++) begin
        a_q[i]  <= in_a[i];
        b_q[i]  <= in_b[i];
        c_q[i]  <= in_c[i];
        ab_q[i] <= (COORD_W+1)'(in_b[i]) - (COORD_W+1)'(in_a[i]);
        ac_q[i] <= (COORD_W+1)'(in_c[i]) - (COORD_W+1)'(in_a[i]);
        ap_q[i] <= (COORD_W+1)'(qp_q[i]) - (COORD_W+1)'(in_a[i]);
        bc_q[i] <= (COORD_W+1)'(in_c[i]) - (COORD_W+1)'(in_b[i]);
      end
    end
    if (state_q == ST_SHIFT) begin
      for (int i = 0; i < 3; i++) begin
        sb_q[i] <= 31'(ab_q[i] >>> shamt);
        sc_q[i] <= 31'(ac_q[i] >>> shamt);
        sp_q[i] <= 31'(ap_q[i] >>> shamt);
        bp_q[i] <= 31'(ap_q[i] >>> shamt) - 31'(ab_q[i] >>> shamt);
        cp_q[i] <= 31'(ap_q[i] >>> shamt) - 31'(ac_q[i] >>> shamt);
      end
    end
    if (state_q == ST_DOT && cnt_q == 4'd4) begin
      d_q[grp_q] <= acc[63:0];
    end
    if (state_q == ST_VPROD && cnt_q == 4'd9) begin
      v_q[grp_q[1:0]] <= acc;
    end
    if (state_q == ST_SEL) begin
      region_q   <= sel_region;
      num_q      <= sel_num;
      den_q      <= sel_den;
      interior_q <= (sel_region == REG_IN);
      div_idx_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        unique case (sel_region)
          REG_B, REG_BC: begin
            pt_q[i]     <= b_q[i];
            pt_acc_q[i] <= 36'(b_q[i]);
          end
          REG_C: begin
            pt_q[i]     <= c_q[i];
            pt_acc_q[i] <= 36'(c_q[i]);
          end
          default: begin
            pt_q[i]     <= a_q[i];
            pt_acc_q[i] <= 36'(a_q[i]);
          end
        endcase
      end
    end
    if (state_q == ST_DIVW && div_done) begin
      w_q[div_idx_q] <= div_q;
      div_idx_q      <= 1'b1;
      num_q          <= v_q[0];
    end
    if (state_q == ST_TERM && cnt_q == 4'd2) begin
      pt_acc_q[tk] <= tedge[COORD_W] ? pt_acc_q[tk] - $signed({3'b000, tval})
                                     : pt_acc_q[tk] + $signed({3'b000, tval});
    end
    if (state_q == ST_SAT) begin
      for (int i = 0; i < 3; i++) begin
        priority if (pt_acc_q[i] > 36'sh0_7FFF_FFFF) pt_q[i] <= 32'sh7FFF_FFFF;
        else if (pt_acc_q[i] < -36'sh0_8000_0000) pt_q[i] <= 32'sh8000_0000;
        else pt_q[i] <= 32'(pt_acc_q[i]);
      end
    end
    if (state_q == ST_DIST && cnt_q == 4'd4) begin
      dist_q <= dist_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_q       <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      searched_q  <= 1'b0;
      tri_cnt_q   <= '0;
      best_dist_q <= '1;
      best_idx_q  <= '0;
      best_reg_q  <= REG_A;
      have_best_q <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        qp_q[i]      <= '0;
        best_pt_q[i] <= '0;
      end
    end else begin
      if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (acc_in) begin
            if (!s_axis_tuser) begin
              for (int i = 0; i < 3; i++) begin
                qp_q[i]      <= in_a[i];
                best_pt_q[i] <= '0;
              end
              tri_cnt_q   <= '0;
              best_dist_q <= '1;
              best_idx_q  <= '0;
              best_reg_q  <= REG_A;
              have_best_q <= 1'b0;
            end else begin
              last_q     <= s_axis_tlast;
              searched_q <= (tri_cnt_q < CNT_W'(MAX_TRI));
              state_q    <= (tri_cnt_q < CNT_W'(MAX_TRI)) ? ST_SHIFT : ST_NEXT;
            end
          end
        end
        ST_SHIFT: begin
          state_q <= ST_DOT;
          grp_q   <= '0;
          cnt_q   <= '0;
        end
        ST_DOT: begin
          if (cnt_q == 4'd4) begin
            cnt_q <= '0;
            if (grp_q == 3'd5) begin
              grp_q   <= '0;
              state_q <= ST_VPROD;
            end else begin
              grp_q <= grp_q + 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_VPROD: begin
          if (cnt_q == 4'd9) begin
            cnt_q <= '0;
            if (grp_q == 3'd2) begin
              grp_q   <= '0;
              state_q <= ST_SEL;
            end else begin
              grp_q <= grp_q + 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SEL: begin
          priority if (sel_skip) begin
            state_q <= ST_NEXT;
          end else if (sel_region == REG_A || sel_region == REG_B ||
                       sel_region == REG_C) begin
            state_q <= ST_DIST;
          end else begin
            state_q <= ST_DIVGO;
          end
        end
        ST_DIVGO: begin
          state_q <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            if (interior_q && !div_idx_q) begin
              state_q <= ST_DIVGO;
            end else begin
              grp_q   <= '0;
              cnt_q   <= '0;
              state_q <= ST_TERM;
            end
          end
        end
        ST_TERM: begin
          if (cnt_q == 4'd2) begin
            cnt_q <= '0;
            if (grp_q == n_terms - 3'd1) begin
              state_q <= ST_SAT;
            end else begin
              grp_q <= grp_q + 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SAT: begin
          cnt_q   <= '0;
          state_q <= ST_DIST;
        end
        ST_DIST: begin
          if (cnt_q == 4'd4) begin
            cnt_q   <= '0;
            state_q <= ST_CMP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_CMP: begin
          if ({1'b0, dist_q} < best_dist_q) begin
            best_dist_q <= {1'b0, dist_q};
            best_idx_q  <= tri_cnt_q[IDX_W-1:0];
            best_reg_q  <= region_q;
            have_best_q <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              best_pt_q[i] <= pt_q[i];
            end
          end
          state_q <= ST_NEXT;
        end
        ST_NEXT: begin
          if (searched_q) begin
            tri_cnt_q <= tri_cnt_q + 1'b1;
          end
          state_q <= last_q ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            if (have_best_q) begin
              m_data_q <= {1'b0, best_dist_q[DIST_W-1:0], best_reg_q, best_pt_q[2],
                           best_pt_q[1], best_pt_q[0], best_idx_q, 1'b1};
            end else begin
              m_data_q <= '0;
            end
            for (int i = 0; i < 3; i++) begin
              best_pt_q[i] <= '0;
            end
            tri_cnt_q   <= '0;
            best_dist_q <= '1;
            best_idx_q  <= '0;
            best_reg_q  <= REG_A;
            have_best_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `NPTP_ASSERT_IMP(a_empty_search, !have_best_q, best_dist_q == '1, "empty search holds a distance")
  `NPTP_ASSERT(a_count_bound, tri_cnt_q <= CNT_W'(MAX_TRI), "triangle count overran")
  `NPTP_ASSERT_IMP(a_div_done, div_done, state_q == ST_DIVW, "divider finished unexpectedly")
endmodule

FILE: rtl/nptp_mac.sv
// Shared multiply-accumulate unit: a registered 34x34 signed product added,
// shifted and optionally negated, into a 128-bit accumulator. Uses nptp_pkg.
`timescale 1ns / 1ps
module nptp_mac
  import nptp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctl_t                ctl_i,
  input  opnd_t                   a_i,
  input  opnd_t                   b_i,
  output logic signed [ACC_W-1:0] acc_o
);
  logic signed [PROD_W-1:0] prod_q;
  mac_ctl_t                 ctl_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, term, shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_d;
  end

  always_comb begin
    term = ACC_W'(prod_q);
    if (ctl_q.neg) begin
      term = -term;
    end
    unique case (ctl_q.sh)
      SH_32:   shifted = term <<< 32;
      SH_64:   shifted = term <<< 64;
      default: shifted = term;
    endcase
    acc_d = acc_q;
    if (ctl_q.valid) begin
      acc_d = (ctl_q.clear ? '0 : acc_q) + shifted;
    end
  end

  assign acc_o = acc_q;
endmodule

FILE: rtl/nptp_div.sv
// Radix-2 restoring divider giving a Q1.32 weight num/den, one bit per cycle.
// Uses nptp_pkg; the divisor is positive whenever a division is started.
`timescale 1ns / 1ps
module nptp_div
  import nptp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ACC_W-1:0]  num_i,
  input  logic [ACC_W-1:0]  den_i,
  output logic              done_o,
  output logic [FRAC_W-1:0] q_o
);
  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0]     rem_q, den_q, rem_sh;
  logic [FRAC_W-1:0]    q_q;
  logic                 ge;

  assign rem_sh = {rem_q[ACC_W-2:0], 1'b0};
  assign ge     = rem_sh >= den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (num_i[ACC_W-1] || num_i == '0 || num_i >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= DIV_CNT_W'(DIV_STEPS);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      if (num_i[ACC_W-1] || num_i == '0) begin
        q_q <= '0;
      end else if (num_i >= den_i) begin
        q_q <= {1'b1, {(FRAC_W-1){1'b0}}};
      end else begin
        q_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= ge ? rem_sh - den_q : rem_sh;
      q_q   <= {q_q[FRAC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;
endmodule
